/* rtl/rap_pkg.sv */
// shared types and constants of the rectangle atlas packer
// no dependencies
package rap_pkg;

	localparam int ID_W   = 32;
	localparam int DIM_W  = 11;
	localparam int PROD_W = 2 * DIM_W;
	localparam int AREA_W = 27;
	localparam int SW_W   = 14;
	localparam int SH_W   = 15;
	localparam int PX_W   = 13;
	localparam int PY_W   = 14;

	localparam int MAX_RECTS_DEF = 64;
	localparam int FIFO_DEPTH    = 4;

	localparam logic [SW_W-1:0]   START_WIDTH = 14'd128;
	localparam logic [SW_W-1:0]   WIDTH_CAP   = 14'd8192;
	localparam logic [AREA_W-1:0] AREA_MAX    = {AREA_W{1'b1}};

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
		logic              last;
		logic [PROD_W-1:0] prod;
	} item_t;

endpackage

/* rtl/rap_front.sv */
// front end: input beat register with area product
// depends on rap_pkg
module rap_front import rap_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [ID_W-1:0]  in_id,
	input  logic [DIM_W-1:0] in_w,
	input  logic [DIM_W-1:0] in_h,
	input  logic        in_last,
	input  logic        q_full,
	output logic        push,
	output item_t       push_item
);

	logic  v_s1;
	item_t item_s1;

	assign push      = v_s1 && !q_full;
	assign in_ready  = !v_s1 || !q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				v_s1 <= 1'b1;
			else if (push)
				v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.id   <= in_id;
			item_s1.w    <= in_w;
			item_s1.h    <= in_h;
			item_s1.last <= in_last;
			item_s1.prod <= in_w * in_h;
		end
	end

endmodule

/* rtl/rap_fifo.sv */
// short item queue between front and back
// depends on rap_pkg
module rap_fifo import rap_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output item_t head
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	item_t          mem_q [FIFO_DEPTH];
	logic [PW-1:0]  wp_q, rp_q;
	logic [CW-1:0]  cnt_q;

	assign full  = (cnt_q == CW'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == PW'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == PW'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* rtl/rap_back.sv */
// back end: rectangle store, width choice, selection sort, first-fit scan, result emit
// depends on rap_pkg
module rap_back import rap_pkg::*; #(
	parameter int MAX_RECTS = MAX_RECTS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_empty,
	input  item_t q_head,
	output logic  pop,
	output logic  out_valid,
	input  logic  out_ready,
	output logic [ID_W-1:0] out_id,
	output logic [PX_W-1:0] out_x,
	output logic [PY_W-1:0] out_y,
	output logic  out_ok,
	output logic [SW_W-1:0] out_sw,
	output logic [SH_W-1:0] out_sh,
	output logic  out_last
);

	localparam int IW = $clog2(MAX_RECTS);
	localparam int CW = $clog2(MAX_RECTS + 1);

	localparam logic [3:0] ST_LOAD  = 4'd0;
	localparam logic [3:0] ST_WSEL  = 4'd1;
	localparam logic [3:0] ST_SEL   = 4'd2;
	localparam logic [3:0] ST_PICK  = 4'd3;
	localparam logic [3:0] ST_CAND  = 4'd4;
	localparam logic [3:0] ST_SCAN  = 4'd5;
	localparam logic [3:0] ST_ERD   = 4'd6;
	localparam logic [3:0] ST_EOUT  = 4'd7;
	localparam logic [3:0] ST_EHOLD = 4'd8;

	typedef struct packed {
		logic [DIM_W-1:0] h;
		logic [DIM_W-1:0] w;
		logic [ID_W-1:0]  id;
	} rect_t;

	typedef struct packed {
		logic [SH_W-1:0] dy;
		logic [PY_W-1:0] y;
		logic [SW_W-1:0] dx;
		logic [SW_W-1:0] x;
	} bound_t;

	typedef struct packed {
		logic            ok;
		logic [PY_W-1:0] y;
		logic [PX_W-1:0] x;
		logic [ID_W-1:0] id;
	} res_t;

	rect_t  rect_mem [MAX_RECTS];
	bound_t pl_mem   [MAX_RECTS];
	res_t   res_mem  [MAX_RECTS];
	rect_t  rd_rect_q;
	bound_t rd_pl_q;
	res_t   rd_res_q;

	logic [3:0]        state_q;
	logic [CW-1:0]     cnt_q, k_q, iss_q, didx_q, np_q, e_q;
	logic [AREA_W-1:0] area_q, sq_q;
	logic [SW_W-1:0]   wd_q;
	logic [SH_W-1:0]   rows_q;
	logic              dv_q, prev_v_q, best_v_q;
	logic [DIM_W-1:0]  prev_w_q, best_w_q, best_h_q;
	logic [CW-1:0]     prev_idx_q, best_idx_q;
	logic [ID_W-1:0]   best_id_q;
	logic [SW_W-1:0]   x_q;
	logic [PY_W-1:0]   y_q;

	logic [AREA_W:0]   area_sum;
	logic              rect_re, pl_re, store_ok;
	logic              eligible, take, fits_row, last_row, overlap;
	logic [SW_W:0]     x_end;
	logic [SH_W-1:0]   y_end;
	logic              res_we, pl_we;
	res_t              res_wd;
	logic              do_place, do_fail;

	assign pop      = (state_q == ST_LOAD) && !q_empty;
	assign store_ok = cnt_q < CW'(MAX_RECTS);
	assign area_sum = {1'b0, area_q} + (AREA_W+1)'(q_head.prod);
	assign rect_re  = (state_q == ST_SEL) && (iss_q < cnt_q);
	assign pl_re    = (state_q == ST_SCAN) && (iss_q < np_q);

	assign eligible = !prev_v_q || (rd_rect_q.w < prev_w_q) ||
		((rd_rect_q.w == prev_w_q) && (didx_q > prev_idx_q));
	assign take     = (state_q == ST_SEL) && dv_q && eligible &&
		(!best_v_q || (rd_rect_q.w > best_w_q));

	assign x_end    = {1'b0, x_q} + (SW_W+1)'(best_w_q);
	assign y_end    = {1'b0, y_q} + SH_W'(best_h_q);
	assign fits_row = x_end <= {1'b0, wd_q};
	assign last_row = {1'b0, y_q} == (SH_W'({wd_q, 1'b0}) - 1'b1);
	assign overlap  = ({1'b0, rd_pl_q.x} < x_end) && (x_q < rd_pl_q.dx) &&
		({1'b0, rd_pl_q.y} < y_end) && (y_q < rd_pl_q.dy[PY_W-1:0] ||
		rd_pl_q.dy[SH_W-1]);

	// placement outcome of the current rectangle
	always_comb begin
		do_place = 1'b0;
		do_fail  = 1'b0;
		unique case (state_q)
			ST_PICK: do_fail = best_w_q > DIM_W'(0) && {3'b0, best_w_q} > wd_q;
			ST_CAND: begin
				if (!fits_row)
					do_fail = last_row;
				else
					do_place = (np_q == '0);
			end
			ST_SCAN: do_place = dv_q && !overlap && (didx_q + 1'b1 == np_q);
			default: ;
		endcase
	end

	assign res_we    = do_place || do_fail;
	assign pl_we     = do_place;
	assign res_wd.ok = do_place;
	assign res_wd.id = best_id_q;
	assign res_wd.x  = do_place ? x_q[PX_W-1:0] : '0;
	assign res_wd.y  = do_place ? y_q : '0;

	always_ff @(posedge clk) begin
		if (pop && store_ok)
			rect_mem[cnt_q[IW-1:0]] <= '{h: q_head.h, w: q_head.w, id: q_head.id};
		if (rect_re)
			rd_rect_q <= rect_mem[iss_q[IW-1:0]];
		if (pl_we)
			pl_mem[np_q[IW-1:0]] <= '{dy: y_end, y: y_q, dx: x_end[SW_W-1:0], x: x_q};
		if (pl_re)
			rd_pl_q <= pl_mem[iss_q[IW-1:0]];
		if (res_we)
			res_mem[k_q[IW-1:0]] <= res_wd;
		if (state_q == ST_ERD)
			rd_res_q <= res_mem[e_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EOUT) begin
			out_id <= rd_res_q.id;
			out_x  <= rd_res_q.x;
			out_y  <= rd_res_q.y;
			out_ok <= rd_res_q.ok;
			out_sw <= wd_q;
			out_sh <= rows_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			cnt_q      <= '0;
			area_q     <= '0;
			wd_q       <= START_WIDTH;
			sq_q       <= '0;
			rows_q     <= SH_W'(1);
			k_q        <= '0;
			iss_q      <= '0;
			didx_q     <= '0;
			dv_q       <= 1'b0;
			np_q       <= '0;
			e_q        <= '0;
			prev_v_q   <= 1'b0;
			prev_w_q   <= '0;
			prev_idx_q <= '0;
			best_v_q   <= 1'b0;
			best_w_q   <= '0;
			best_h_q   <= '0;
			best_idx_q <= '0;
			best_id_q  <= '0;
			x_q        <= '0;
			y_q        <= '0;
			out_valid  <= 1'b0;
			out_last   <= 1'b0;
		end else begin
			if (take) begin
				best_v_q   <= 1'b1;
				best_w_q   <= rd_rect_q.w;
				best_h_q   <= rd_rect_q.h;
				best_id_q  <= rd_rect_q.id;
				best_idx_q <= didx_q;
			end
			// the picked rectangle leaves the sort, placed or not
			if (state_q == ST_PICK) begin
				prev_v_q   <= 1'b1;
				prev_w_q   <= best_w_q;
				prev_idx_q <= best_idx_q;
				best_v_q   <= 1'b0;
			end
			if (do_place) begin
				np_q <= np_q + 1'b1;
				if (y_end > rows_q)
					rows_q <= y_end;
			end
			if (res_we) begin
				k_q   <= k_q + 1'b1;
				iss_q <= '0;
				dv_q  <= 1'b0;
				if (k_q + 1'b1 == cnt_q) begin
					state_q <= ST_ERD;
					e_q     <= '0;
				end else begin
					state_q <= ST_SEL;
				end
			end else begin
				unique case (state_q)
					ST_LOAD: begin
						if (pop) begin
							if (store_ok) begin
								cnt_q  <= cnt_q + 1'b1;
								area_q <= area_sum[AREA_W] ? AREA_MAX : area_sum[AREA_W-1:0];
							end
							if (q_head.last) begin
								state_q <= ST_WSEL;
								wd_q    <= START_WIDTH;
								sq_q    <= AREA_W'(START_WIDTH) * AREA_W'(START_WIDTH);
							end
						end
					end
					ST_WSEL: begin
						if (sq_q < area_q && wd_q < WIDTH_CAP) begin
							wd_q <= {wd_q[SW_W-2:0], 1'b0};
							sq_q <= {sq_q[AREA_W-3:0], 2'b00};
						end else begin
							rows_q   <= SH_W'(1);
							k_q      <= '0;
							np_q     <= '0;
							prev_v_q <= 1'b0;
							best_v_q <= 1'b0;
							iss_q    <= '0;
							dv_q     <= 1'b0;
							state_q  <= ST_SEL;
						end
					end
					ST_SEL: begin
						if (rect_re)
							iss_q <= iss_q + 1'b1;
						dv_q   <= rect_re;
						didx_q <= iss_q;
						if (dv_q && (didx_q + 1'b1 == cnt_q))
							state_q <= ST_PICK;
					end
					ST_PICK: begin
						x_q        <= '0;
						y_q        <= '0;
						state_q    <= ST_CAND;
					end
					ST_CAND: begin
						if (!fits_row) begin
							y_q <= y_q + 1'b1;
							x_q <= '0;
						end else begin
							iss_q   <= '0;
							dv_q    <= 1'b0;
							state_q <= ST_SCAN;
						end
					end
					ST_SCAN: begin
						if (pl_re)
							iss_q <= iss_q + 1'b1;
						dv_q   <= pl_re;
						didx_q <= iss_q;
						if (dv_q && overlap) begin
							// jump to the right edge of the first blocker
							x_q     <= rd_pl_q.dx;
							state_q <= ST_CAND;
						end
					end
					ST_ERD: state_q <= ST_EOUT;
					ST_EOUT: begin
						out_valid <= 1'b1;
						out_last  <= (e_q + 1'b1 == cnt_q);
						state_q   <= ST_EHOLD;
					end
					ST_EHOLD: begin
						if (out_ready) begin
							out_valid <= 1'b0;
							if (out_last) begin
								cnt_q   <= '0;
								area_q  <= '0;
								state_q <= ST_LOAD;
							end else begin
								e_q     <= e_q + 1'b1;
								state_q <= ST_ERD;
							end
						end
					end
					default: state_q <= ST_LOAD;
				endcase
			end
		end
	end

endmodule

/* rtl/rectangle_atlas_packer.sv */
// a beat passes the front register and the queue; loading takes one beat a cycle while the
// queue is not empty; packing: per rectangle a selection pass over the store, then a scan
// of the np placed bounds per candidate position (one bound read a cycle from the placed
// memory); emit: one result at a time, held until taken; the input can still fill the queue
// reset: arst_n clears control state, count and area; stores are not cleared (no sweep)
// top level of the rectangle atlas packer, depends on rap_pkg, rap_front, rap_fifo, rap_back
module rectangle_atlas_packer import rap_pkg::*; #(
	parameter int MAX_RECTS = MAX_RECTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // image_id[31:0], rect_width[42:32], rect_height[53:43], zero pad
	input  logic        s_tlast,  // last_item
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,  // placed_id, pos_x, pos_y, sheet_width, sheet_height
	output logic [0:0]  m_tuser,  // was_placed
	output logic        m_tlast   // last_result
);

	// front to queue
	logic  push, q_full, q_empty, pop;
	item_t push_item, q_head;

	// result fields from the back end output register
	logic [ID_W-1:0] o_id;
	logic [PX_W-1:0] o_x;
	logic [PY_W-1:0] o_y;
	logic [SW_W-1:0] o_sw;
	logic [SH_W-1:0] o_sh;
	logic            o_ok;

	rap_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_id     (s_tdata[31:0]),
		.in_w      (s_tdata[42:32]),
		.in_h      (s_tdata[53:43]),
		.in_last   (s_tlast),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// decouples beat loading from the long packing phase
	rap_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	rap_back #(
		.MAX_RECTS (MAX_RECTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_id    (o_id),
		.out_x     (o_x),
		.out_y     (o_y),
		.out_ok    (o_ok),
		.out_sw    (o_sw),
		.out_sh    (o_sh),
		.out_last  (m_tlast)
	);

	assign m_tdata = {o_sh, o_sw, o_y, o_x, o_id};
	assign m_tuser = o_ok;

`ifndef SYNTH
	// after the final beat of a set the back end returns to loading
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("result beat right after last beat");

	a_width_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot(m_tdata[72:59]))
		else $error("sheet width not a power of two");

	a_unplaced_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata[58:32] == 27'd0))
		else $error("unplaced rectangle with nonzero position");

	a_height_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[87:73] != 15'd0))
		else $error("zero sheet height");
`endif

endmodule
